// File: design/utf8c_pkg.sv
// shared types and constants for the utf-8 text check block
package utf8c_pkg;

	localparam logic [31:0] MAX_TEXT_LEN_DEF = 32'd65535;
	localparam int unsigned LEN_W = 16;
	localparam logic [LEN_W-1:0] LEN_LIMIT = 16'hFFFF;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_MATCH = 8'h80;
	localparam logic [7:0] PAD_MAX    = 8'h10;
	localparam logic [7:0] CTRL_END   = 8'h20;
	localparam logic [7:0] DEL_CHAR   = 8'h7F;

	typedef struct packed {
		logic [1:0]       pend;
		logic [LEN_W-1:0] pos;
		logic             ended;
		logic             err;
	} scan_state_t;

	typedef struct packed {
		logic             valid_res;
		logic [LEN_W-1:0] text_length;
		logic             padding_seen;
	} scan_res_t;

endpackage

// File: design/utf8c_if.sv
// handshake channels for message bytes and check results
interface utf8c_in_if;
	import utf8c_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
	modport mon (input valid, input data_byte, input last, input ready);
endinterface

interface utf8c_out_if;
	import utf8c_pkg::*;
	logic             valid;
	logic             ready;
	logic             valid_res;
	logic [LEN_W-1:0] text_length;
	logic             padding_seen;

	modport source (output valid, output valid_res, output text_length, output padding_seen,
		input ready);
	modport sink (input valid, input valid_res, input text_length, input padding_seen,
		output ready);
	modport mon (input valid, input valid_res, input text_length, input padding_seen,
		input ready);
endinterface

// File: design/utf8_text_check_with_pad_end_top.sv
// Loose UTF-8 text check with padding end, one message byte per transaction.
//
// Channel msg carries data_byte and last; channel res carries valid_res,
// text_length and padding_seen. One result transaction is produced for every
// msg transaction with last set, none for other bytes.
// Each byte is captured in an input register and scanned from there
// by a short block of logic into the scan state and a result register.
// Throughput is one byte per cycle while no last byte stalls; res.valid
// rises once the last byte has passed the input register into the result
// register. The result register sits between the scanner and the receiver,
// so bytes keep flowing while a result waits; only a last byte stalls when
// the result register is still full and res.ready is low.
// Invalid messages report text_length and padding_seen as zero.
// Reset (arst_n low) empties both registers and clears the scan state; the
// state also returns to zero after each last byte, ready for the next message.
module utf8_text_check_with_pad_end_top
	import utf8c_pkg::*;
#(
	parameter logic [31:0] MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	utf8c_in_if.sink    msg,
	utf8c_out_if.source res
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	scan_state_t st_q;
	scan_state_t st_nxt;
	scan_res_t   scan_res;
	scan_res_t   res_q;
	logic        res_valid_q;
	logic        out_free;
	logic        s1_go;

	assign out_free  = !res_valid_q || res.ready;
	assign s1_go     = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.last;
		end
	end

	utf8c_scan #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_scan (
		.st       (st_q),
		.data_byte(data_s1),
		.last     (last_s1),
		.st_nxt   (st_nxt),
		.result   (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_go) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_q <= scan_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.valid_res    = res_q.valid_res;
	assign res.text_length  = res_q.text_length;
	assign res.padding_seen = res_q.padding_seen;

endmodule

// File: design/utf8c_scan.sv
// per-byte utf-8 scan: next state and end-of-message result
module utf8c_scan
	import utf8c_pkg::*;
#(
	parameter logic [31:0] MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
	input  scan_state_t st,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output scan_state_t st_nxt,
	output scan_res_t   result
);

	localparam logic [LEN_W-1:0] CountCap =
		(MAX_TEXT_LEN < 32'(LEN_LIMIT)) ? MAX_TEXT_LEN[LEN_W-1:0] : LEN_LIMIT;

	scan_state_t t;
	logic        count;
	logic        fin_err;

	always_comb begin
		t = st;
		count = 1'b0;
		if (!st.err && !st.ended) begin
			if (st.pend != 2'd0) begin
				if ((data_byte & CONT_MASK) != CONT_MATCH) begin
					t.err = 1'b1;
				end else begin
					t.pend = st.pend - 2'd1;
					count = 1'b1;
				end
			end else if (!data_byte[7]) begin
				// low control byte marks where padding starts
				if (data_byte <= PAD_MAX) begin
					t.ended = 1'b1;
				end else if (data_byte < CTRL_END || data_byte == DEL_CHAR) begin
					t.err = 1'b1;
				end else begin
					count = 1'b1;
				end
			end else begin
				// loose lead rule, bit 6 not looked at
				if (!data_byte[5]) begin
					t.pend = 2'd1;
				end else if (!data_byte[4]) begin
					t.pend = 2'd2;
				end else begin
					t.pend = 2'd3;
				end
				count = 1'b1;
			end
		end
		if (count && t.pos < CountCap) begin
			t.pos = t.pos + LEN_W'(1);
		end

		fin_err = t.err || (!t.ended && t.pend != 2'd0);
		result.valid_res    = !fin_err;
		result.text_length  = fin_err ? '0 : t.pos;
		result.padding_seen = !fin_err && t.ended;

		st_nxt = last ? '0 : t;
	end

endmodule

// File: design/utf8c_checker.sv
// port-level checks for the utf-8 text check block
module utf8c_checker
	import utf8c_pkg::*;
#(
	parameter logic [31:0] MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic             valid_res,
	input logic [LEN_W-1:0] text_length,
	input logic             padding_seen
);

	localparam logic [LEN_W-1:0] CountCap =
		(MAX_TEXT_LEN < 32'(LEN_LIMIT)) ? MAX_TEXT_LEN[LEN_W-1:0] : LEN_LIMIT;

	// a stalled result transaction stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a failed message carries no length and no padding mark
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> text_length == '0 && !padding_seen)
		else $error("failed message with non-zero fields");

	a_pad_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && padding_seen |-> valid_res)
		else $error("padding reported on failed message");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> text_length <= CountCap)
		else $error("text length above cap");

	// a result must not rise too soon after reset is released
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(arst_n, 2))
		else $error("result too soon after reset");

endmodule

bind utf8_text_check_with_pad_end_top utf8c_checker #(
	.MAX_TEXT_LEN(MAX_TEXT_LEN)
) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.valid_res   (res.valid_res),
	.text_length (res.text_length),
	.padding_seen(res.padding_seen)
);
